>>> rtl/core/harmony_search_engine_defines.svh
// Assertion macros for the harmony search engine.
// Used by the top level only; no other dependencies.
`ifndef HARMONY_SEARCH_ENGINE_DEFINES_SVH
`define HARMONY_SEARCH_ENGINE_DEFINES_SVH
// assert that a condition implies a consequence on the same edge
`define HSE_ASSERT_IMP(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("hse check failed");
// assert that a condition implies a consequence on the next edge
`define HSE_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("hse check failed");
`endif

>>> rtl/core/hse_pkg.sv
// Package for the harmony search engine: request codes, config indices, sequencer states.
// No dependencies.
package hse_pkg;
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_IMPROVISE = 2'd1;
    localparam logic [1:0] FUNC_EXTERNAL = 2'd2;
    localparam logic [2:0] CFG_CONSIDER = 3'd0;
    localparam logic [2:0] CFG_ADJUST = 3'd1;
    localparam logic [2:0] CFG_BANDWIDTH = 3'd2;
    localparam logic [2:0] CFG_LOWER = 3'd3;
    localparam logic [2:0] CFG_UPPER = 3'd4;
    localparam logic [63:0] SAT64 = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_READ,
        ST_ADJ,
        ST_CLAMP,
        ST_SQ,
        ST_T1,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_SCALE,
        ST_ACC,
        ST_DECIDE,
        ST_COPY,
        ST_SCAN,
        ST_SCAN_B,
        ST_OUT
    } state_t;
endpackage

>>> rtl/core/hse_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/core/hse_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
// No dependencies.
module hse_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);
    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;
endmodule

>>> rtl/core/harmony_search_engine.sv
// Harmony search engine top level: sequencer, datapath and memories.
// Depends on hse_pkg, hse_ram, hse_mul and harmony_search_engine_defines.svh.
//
// channel | direction | handshake
// in      | input     | in_valid / in_stall
// out     | output    | out_valid / out_stall
// cfg     | input     | cfg_we, cfg_index, cfg_data
//
// Each element passes READ, ADJ and CLAMP, then SQ, T1, M0 to M4 and SCALE (skipped
// for the first element of a vector), then ACC; the shared 32x32 multiplier serves
// the fitness steps. After the last element, DECIDE follows: a committed vector is copied
// into the harmony store (COPY) and the slots are rescanned (SCAN, SCAN_B) before OUT.
// Reset clears control state; memories are undefined until written.
// in_stall stays high from acceptance until the result is taken.
`include "harmony_search_engine_defines.svh"
module harmony_search_engine #(
    parameter int MEMORY_SLOTS = 16,
    parameter int DIMENSIONS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [15:0] draw_consider,
    input  logic [3:0]  pick_slot,
    input  logic [15:0] draw_adjust,
    input  logic signed [15:0] adjust_fraction,
    input  logic signed [31:0] fresh_value,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] element_value,
    output logic        vector_done,
    output logic [63:0] vector_fitness,
    output logic        accepted,
    output logic [3:0]  worst_slot_out,
    output logic [3:0]  best_slot_out,
    output logic [63:0] best_fitness_out
);
    localparam int SW = (MEMORY_SLOTS > 1) ? $clog2(MEMORY_SLOTS) : 1;
    localparam int DW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam int AW = $clog2(MEMORY_SLOTS * DIMENSIONS);

    hse_pkg::state_t state_reg, state_next;

    logic [16:0] consider_rate_reg, adjust_rate_reg;
    logic [30:0] bandwidth_reg;
    logic signed [31:0] lower_bound_reg, upper_bound_reg;

    logic [1:0]  func_reg;
    logic [15:0] draw_adjust_reg;
    logic [SW-1:0] pick_reg;
    logic signed [15:0] frac_reg;
    logic last_reg;
    logic use_store_reg;

    logic signed [33:0] v_reg, v_next;
    logic signed [31:0] prev_reg;
    logic [DW-1:0] dim_reg;
    logic [DW:0]   count_reg;
    logic [SW-1:0] load_reg;
    logic [63:0] sum_reg, sq_reg, m_reg;
    logic [63:0] p_ll_reg, p_lh_reg, term_sat_reg, t2sq_reg, s100_reg, pt_reg;
    logic [SW-1:0] worst_reg, best_reg;
    logic [MEMORY_SLOTS-1:0] valid_reg;
    logic [63:0] slot_fit_reg [MEMORY_SLOTS];
    logic acc_reg;
    logic [DW:0] cp_reg;
    logic [SW:0] scan_reg;
    logic [SW-1:0] cand_w_reg, cand_b_reg;
    logic found_w_reg, found_b_reg;
    logic [SW-1:0] target_reg;
    logic rescan_best_reg;
    logic signed [31:0] element_value_reg;
    logic vector_done_reg;
    logic [63:0] vector_fitness_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    hse_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

    logic store_we;
    logic [AW-1:0] store_waddr, store_raddr;
    logic [31:0] store_rdata, store_wdata;
    logic cand_we;
    logic [DW-1:0] cand_waddr, cand_raddr;
    logic [31:0] cand_rdata;

    hse_ram #(.WIDTH(32), .DEPTH(MEMORY_SLOTS * DIMENSIONS)) u_store (
        .clk(clk), .we(store_we), .waddr(store_waddr), .wdata(store_wdata),
        .raddr(store_raddr), .rdata(store_rdata));
    hse_ram #(.WIDTH(32), .DEPTH(1 << DW)) u_cand (
        .clk(clk), .we(cand_we), .waddr(cand_waddr), .wdata(v_reg[31:0]),
        .raddr(cand_raddr), .rdata(cand_rdata));

    logic in_acc, out_acc;
    assign in_acc = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // absolute value of term1 = b*2^16 - a^2 (sq_reg is a^2, exact)
    logic signed [65:0] t1;
    logic [63:0] t1_abs;
    logic signed [33:0] t2;
    logic [31:0] t2_abs;
    logic [31:0] prev_abs;
    assign t1 = (66'(signed'(v_reg[31:0])) <<< 16) - $signed({2'b00, sq_reg});
    assign t1_abs = t1[65] ? 64'(-t1) : t1[63:0];
    assign t2 = 34'sd65536 - 34'(prev_reg);
    assign t2_abs = t2[33] ? 32'(-t2) : t2[31:0];
    assign prev_abs = prev_reg[31] ? 32'(-prev_reg) : prev_reg;

    // adjust offset: floor(frac*bw/32768); product sign handled by magnitudes
    logic [15:0] frac_abs;
    logic [46:0] off_mag;
    logic signed [33:0] off;
    assign frac_abs = frac_reg[15] ? 16'(-frac_reg) : frac_reg;
    assign off_mag = mul_p[46:0];
    assign off = frac_reg[15] ? -34'((off_mag + 47'd32767) >> 15) : 34'(off_mag >> 15);

    // term1^2 in Q.32 from the three partial products
    logic [65:0] mid_c;
    logic [65:0] hi_c;
    logic [63:0] sq_q32;
    assign mid_c = 66'(p_ll_reg[63:32]) + (66'(p_lh_reg[31:0]) << 1);
    assign hi_c = 66'(mul_p) + (66'(p_lh_reg[63:32]) << 1) + (mid_c >> 32);
    assign sq_q32 = (hi_c[65:32] != '0) ? hse_pkg::SAT64 : {hi_c[31:0], mid_c[31:0]};

    logic [63:0] sum_new;
    assign sum_new = (dim_reg == '0) ? sum_reg
                   : ((sum_reg > hse_pkg::SAT64 - pt_reg) ? hse_pkg::SAT64 : sum_reg + pt_reg);

    logic fit_acc_lt_best;
    assign fit_acc_lt_best = sum_reg < slot_fit_reg[best_reg];

    logic [SW-1:0] scan_idx;
    assign scan_idx = scan_reg[SW-1:0];

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            hse_pkg::ST_ADJ:
            begin
                mul_a = 32'(frac_abs);
                mul_b = {1'b0, bandwidth_reg};
            end
            hse_pkg::ST_SQ:
            begin
                mul_a = prev_abs;
                mul_b = prev_abs;
            end
            hse_pkg::ST_M0:
            begin
                mul_a = t1_abs[31:0];
                mul_b = t1_abs[31:0];
            end
            hse_pkg::ST_M1:
            begin
                mul_a = m_reg[31:0];
                mul_b = m_reg[63:32];
            end
            hse_pkg::ST_M2:
            begin
                mul_a = m_reg[63:32];
                mul_b = m_reg[63:32];
            end
            hse_pkg::ST_M3:
            begin
                mul_a = t2_abs;
                mul_b = t2_abs;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hse_pkg::ST_IDLE: state_next = in_acc ? hse_pkg::ST_READ : hse_pkg::ST_IDLE;
            hse_pkg::ST_READ: state_next = hse_pkg::ST_ADJ;
            hse_pkg::ST_ADJ: state_next = hse_pkg::ST_CLAMP;
            hse_pkg::ST_CLAMP: state_next = (dim_reg != '0) ? hse_pkg::ST_SQ
                                                             : hse_pkg::ST_ACC;
            hse_pkg::ST_SQ: state_next = hse_pkg::ST_T1;
            hse_pkg::ST_T1: state_next = hse_pkg::ST_M0;
            hse_pkg::ST_M0: state_next = hse_pkg::ST_M1;
            hse_pkg::ST_M1: state_next = hse_pkg::ST_M2;
            hse_pkg::ST_M2: state_next = hse_pkg::ST_M3;
            hse_pkg::ST_M3: state_next = hse_pkg::ST_M4;
            hse_pkg::ST_M4: state_next = hse_pkg::ST_SCALE;
            hse_pkg::ST_SCALE: state_next = hse_pkg::ST_ACC;
            hse_pkg::ST_ACC: state_next = last_reg ? hse_pkg::ST_DECIDE : hse_pkg::ST_OUT;
            hse_pkg::ST_DECIDE: state_next = acc_reg ? hse_pkg::ST_COPY : hse_pkg::ST_OUT;
            hse_pkg::ST_COPY: state_next = (cp_reg == count_reg) ? hse_pkg::ST_SCAN
                                                                 : hse_pkg::ST_COPY;
            hse_pkg::ST_SCAN: state_next = (scan_reg == (SW+1)'(MEMORY_SLOTS))
                                           ? hse_pkg::ST_SCAN_B : hse_pkg::ST_SCAN;
            hse_pkg::ST_SCAN_B: state_next = hse_pkg::ST_OUT;
            hse_pkg::ST_OUT: state_next = out_acc ? hse_pkg::ST_IDLE : hse_pkg::ST_OUT;
            default: state_next = hse_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != hse_pkg::ST_IDLE);
        out_valid = (state_reg == hse_pkg::ST_OUT);
        store_raddr = AW'(pick_reg) * AW'(DIMENSIONS) + AW'(dim_reg);
        cand_raddr = cp_reg[DW-1:0];
        cand_we = (state_reg == hse_pkg::ST_ACC);
        cand_waddr = dim_reg;
        store_we = (state_reg == hse_pkg::ST_COPY) && (cp_reg != '0);
        store_waddr = AW'(target_reg) * AW'(DIMENSIONS) + AW'(cp_reg - (DW+1)'(1));
        store_wdata = cand_rdata;
    end

    always_comb
    begin
        v_next = v_reg;
        if (state_reg == hse_pkg::ST_CLAMP && use_store_reg)
        begin
            v_next = 34'(signed'(store_rdata));
            if (17'(draw_adjust_reg) < adjust_rate_reg)
            begin
                v_next = v_next + off;
            end
            if (v_next < 34'(lower_bound_reg))
            begin
                v_next = 34'(lower_bound_reg);
            end
            else if (v_next > 34'(upper_bound_reg))
            begin
                v_next = 34'(upper_bound_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            consider_rate_reg <= 17'd58982;
            adjust_rate_reg <= 17'd19661;
            bandwidth_reg <= 31'd6554;
            lower_bound_reg <= -32'sd327680;
            upper_bound_reg <= 32'sd327680;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hse_pkg::CFG_CONSIDER: consider_rate_reg <= cfg_data[16:0];
                hse_pkg::CFG_ADJUST: adjust_rate_reg <= cfg_data[16:0];
                hse_pkg::CFG_BANDWIDTH: bandwidth_reg <= cfg_data[30:0];
                hse_pkg::CFG_LOWER: lower_bound_reg <= cfg_data;
                hse_pkg::CFG_UPPER: upper_bound_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // datapath registers, loaded by sequencer state
    always_ff @(posedge clk)
    begin
        case (state_reg)
            hse_pkg::ST_IDLE:
            begin
                func_reg <= func;
                draw_adjust_reg <= draw_adjust;
                pick_reg <= pick_slot[SW-1:0];
                frac_reg <= adjust_fraction;
                last_reg <= last;
                v_reg <= 34'(fresh_value);
                use_store_reg <= (func == hse_pkg::FUNC_IMPROVISE)
                    && (17'(draw_consider) < consider_rate_reg);
            end
            hse_pkg::ST_CLAMP: v_reg <= v_next;
            hse_pkg::ST_T1: sq_reg <= mul_p;
            hse_pkg::ST_M0: m_reg <= t1_abs;
            hse_pkg::ST_M1: p_ll_reg <= mul_p;
            hse_pkg::ST_M2: p_lh_reg <= mul_p;
            hse_pkg::ST_M3: term_sat_reg <= sq_q32;
            hse_pkg::ST_M4:
            begin
                t2sq_reg <= mul_p;
                s100_reg <= (term_sat_reg > 64'd184467440737095516) ? hse_pkg::SAT64
                    : (term_sat_reg << 6) + (term_sat_reg << 5) + (term_sat_reg << 2);
            end
            hse_pkg::ST_SCALE:
            begin
                pt_reg <= (s100_reg > hse_pkg::SAT64 - t2sq_reg) ? hse_pkg::SAT64
                                                                 : s100_reg + t2sq_reg;
            end
            hse_pkg::ST_ACC:
            begin
                acc_reg <= last_reg && ((func_reg == hse_pkg::FUNC_LOAD)
                    || (valid_reg[worst_reg] && sum_new < slot_fit_reg[worst_reg]));
                vector_fitness_reg <= last_reg ? sum_new : 64'd0;
                element_value_reg <= v_reg[31:0];
                vector_done_reg <= last_reg;
            end
            hse_pkg::ST_DECIDE:
            begin
                if (acc_reg)
                begin
                    slot_fit_reg[(func_reg == hse_pkg::FUNC_LOAD) ? load_reg : worst_reg]
                        <= vector_fitness_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hse_pkg::ST_IDLE;
            sum_reg <= '0;
            prev_reg <= '0;
            dim_reg <= '0;
            load_reg <= '0;
            worst_reg <= '0;
            best_reg <= '0;
            valid_reg <= '0;
            count_reg <= '0;
            cp_reg <= '0;
            scan_reg <= '0;
            target_reg <= '0;
            found_w_reg <= 1'b0;
            found_b_reg <= 1'b0;
            cand_w_reg <= '0;
            cand_b_reg <= '0;
            rescan_best_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                hse_pkg::ST_ACC:
                begin
                    sum_reg <= sum_new;
                    prev_reg <= v_reg[31:0];
                    count_reg <= (DW+1)'(dim_reg) + (DW+1)'(1);
                    if (!last_reg && (32'(dim_reg) + 32'd1 < 32'(DIMENSIONS)))
                    begin
                        dim_reg <= dim_reg + DW'(1);
                    end
                end
                hse_pkg::ST_DECIDE:
                begin
                    cp_reg <= '0;
                    scan_reg <= '0;
                    found_w_reg <= 1'b0;
                    found_b_reg <= 1'b0;
                    sum_reg <= '0;
                    dim_reg <= '0;
                    if (func_reg == hse_pkg::FUNC_LOAD)
                    begin
                        target_reg <= load_reg;
                        load_reg <= (32'(load_reg) + 32'd1 >= 32'(MEMORY_SLOTS))
                                    ? '0 : load_reg + SW'(1);
                        valid_reg[load_reg] <= 1'b1;
                        rescan_best_reg <= 1'b1;
                    end
                    else
                    begin
                        target_reg <= worst_reg;
                        if (acc_reg)
                        begin
                            valid_reg[worst_reg] <= 1'b1;
                            rescan_best_reg <= 1'b0;
                            if (!valid_reg[best_reg] || fit_acc_lt_best || best_reg == worst_reg)
                            begin
                                best_reg <= worst_reg;
                                rescan_best_reg <= 1'b1;
                            end
                        end
                    end
                end
                hse_pkg::ST_COPY: cp_reg <= cp_reg + (DW+1)'(1);
                hse_pkg::ST_SCAN:
                begin
                    scan_reg <= scan_reg + (SW+1)'(1);
                    if (scan_reg != (SW+1)'(MEMORY_SLOTS) && valid_reg[scan_idx])
                    begin
                        if (!found_w_reg || slot_fit_reg[scan_idx] > slot_fit_reg[cand_w_reg])
                        begin
                            cand_w_reg <= scan_idx;
                            found_w_reg <= 1'b1;
                        end
                        if (!found_b_reg || slot_fit_reg[scan_idx] < slot_fit_reg[cand_b_reg])
                        begin
                            cand_b_reg <= scan_idx;
                            found_b_reg <= 1'b1;
                        end
                    end
                end
                hse_pkg::ST_SCAN_B:
                begin
                    worst_reg <= cand_w_reg;
                    if (rescan_best_reg)
                    begin
                        best_reg <= cand_b_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign element_value = element_value_reg;
    assign vector_done = vector_done_reg;
    assign vector_fitness = vector_fitness_reg;
    assign accepted = vector_done_reg && acc_reg && (func_reg != hse_pkg::FUNC_LOAD);
    assign worst_slot_out = 4'(worst_reg);
    assign best_slot_out = 4'(best_reg);
    assign best_fitness_out = valid_reg[best_reg] ? slot_fit_reg[best_reg] : hse_pkg::SAT64;

    `HSE_ASSERT_IMP(a_stall_busy, (state_reg != hse_pkg::ST_IDLE), in_stall)
    `HSE_ASSERT_NEXT(a_out_hold, (out_valid && out_stall), out_valid)
    `HSE_ASSERT_IMP(a_acc_done, accepted && out_valid, vector_done)
endmodule
